FILE: src/leb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg
// Types and constants shared by the line edit buffer modules.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int LEN_W          = 7;
  localparam int CHAR_W         = 8;
  localparam int KIND_W         = 2;
  localparam int CAP_MAX        = 64;
  localparam int LINE_CHARS_DEF = 64;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 7'd40;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ABORT  = 2'd2;

  localparam logic [CHAR_W-1:0] KEY_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] KEY_EXT       = 8'd224;
  localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'd75;
  localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'd77;
  localparam logic [CHAR_W-1:0] KEY_HOME      = 8'd71;
  localparam logic [CHAR_W-1:0] KEY_END       = 8'd79;
  localparam logic [CHAR_W-1:0] KEY_DELETE    = 8'd83;
  localparam logic [CHAR_W-1:0] KEY_ESC       = 8'd27;
  localparam logic [CHAR_W-1:0] KEY_ENTER     = 8'd13;
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_PRINT_LO  = 8'd32;
  localparam logic [CHAR_W-1:0] KEY_PRINT_HI  = 8'd126;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [LEN_W-1:0]   pos;
    logic [CHAR_W-1:0]  ch;
  } cell_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } st_t;

endpackage

FILE: src/leb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_cell
// One character slot of the line. Takes its left neighbor on insert and its
// right neighbor on delete, depending on where it sits against the position.
// ----------------------------------------------------------------------------
module leb_cell
  import leb_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CHAR_W-1:0] left,
  input  logic [CHAR_W-1:0] right,
  output logic [CHAR_W-1:0] q
);

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(IDX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INS: begin
        if (MY_IDX > ctl.pos) begin
          q <= left;
        end else if (MY_IDX == ctl.pos) begin
          q <= ctl.ch;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl.pos) begin
          q <= right;
        end
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

FILE: src/line_edit_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer
// Keyboard line editor: one edit line with a cursor, held in a row of
// character cells that shift on insert, delete and commit.
// ----------------------------------------------------------------------------
//   channel | signals                                   | dir
//   --------+-------------------------------------------+----
//   in      | in_valid, in_ready, key_byte              | in
//   out     | out_valid, out_ready, event_kind,         | out
//           | line_char, char_valid, line_length,       |
//           | cursor_pos, last                          |
//   cfg     | cfg_valid, cfg_ready, cfg_data            | in
//
// The cell row shifts the whole line at once on an edit.
// Enter emits one beat per character, one per cycle while out_ready takes them,
// from cell 0 as the row shifts left; the input stays held until the last beat.
// A waiting result in the output register blocks new keys until taken.
// Synchronous reset clears the line, cursor, prefix and sets the limit to 40.
// ----------------------------------------------------------------------------
module line_edit_buffer
  import leb_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAR_W-1:0] key_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] event_kind,
  output logic [CHAR_W-1:0] line_char,
  output logic              char_valid,
  output logic [LEN_W-1:0]  line_length,
  output logic [LEN_W-1:0]  cursor_pos,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  localparam int CELLS = (LINE_CHARS < CAP_MAX) ? LINE_CHARS : CAP_MAX;
  localparam logic [LEN_W-1:0] CAP = LEN_W'(CELLS);

  st_t              st, st_next;
  logic [LEN_W-1:0] line_limit;
  logic [LEN_W-1:0] len, len_next;
  logic [LEN_W-1:0] cur, cur_next;
  logic [LEN_W-1:0] rem, rem_next;
  logic             prefix, prefix_next;

  logic [LEN_W-1:0] lim, len_c, cur_c, t_len, t_cur;
  cell_ctl_t        ctl;
  logic [CHAR_W-1:0] chars [CELLS];

  logic              out_load;
  logic [KIND_W-1:0] o_kind;
  logic [CHAR_W-1:0] o_char;
  logic              o_cv;
  logic              o_last;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == ST_IDLE) && (!out_valid || out_ready);

  assign lim   = (line_limit == '0) ? LEN_W'(1) : ((line_limit > CAP) ? CAP : line_limit);
  assign len_c = (len > lim) ? lim : len;
  assign cur_c = (cur > len_c) ? len_c : cur;

  genvar gi;
  generate
    for (gi = 0; gi < CELLS; gi++) begin : g_cell
      logic [CHAR_W-1:0] left_n, right_n;
      if (gi == 0) begin : g_first
        assign left_n = '0;
      end else begin : g_mid_l
        assign left_n = chars[gi-1];
      end
      if (gi == CELLS - 1) begin : g_last
        assign right_n = '0;
      end else begin : g_mid_r
        assign right_n = chars[gi+1];
      end
      leb_cell #(.IDX(gi)) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .left  (left_n),
        .right (right_n),
        .q     (chars[gi])
      );
    end
  endgenerate

  always_comb begin
    st_next     = st;
    len_next    = len;
    cur_next    = cur;
    rem_next    = rem;
    prefix_next = prefix;
    t_len       = len_c;
    t_cur       = cur_c;
    ctl         = '{op: CELL_HOLD, pos: '0, ch: '0};
    out_load    = 1'b0;
    o_kind      = KIND_STATUS;
    o_char      = '0;
    o_cv        = 1'b0;
    o_last      = 1'b1;
    case (st)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          out_load = 1'b1;
          if (prefix) begin
            prefix_next = 1'b0;
            case (key_byte)
              KEY_LEFT: begin
                if (t_cur != '0) t_cur = t_cur - LEN_W'(1);
              end
              KEY_RIGHT: begin
                if (t_cur < t_len && (t_cur + LEN_W'(1)) < lim) t_cur = t_cur + LEN_W'(1);
              end
              KEY_HOME: begin
                t_cur = '0;
              end
              KEY_END: begin
                t_cur = (t_len > lim - LEN_W'(1)) ? lim - LEN_W'(1) : t_len;
              end
              KEY_DELETE: begin
                if (t_cur < t_len) begin
                  ctl   = '{op: CELL_DEL, pos: t_cur, ch: '0};
                  t_len = t_len - LEN_W'(1);
                end
              end
              default: begin
                t_cur = t_cur;
              end
            endcase
          end else if (key_byte == KEY_NUL || key_byte == KEY_EXT) begin
            prefix_next = 1'b1;
          end else if (key_byte == KEY_ESC) begin
            t_len  = '0;
            t_cur  = '0;
            o_kind = KIND_ABORT;
          end else if (key_byte == KEY_ENTER) begin
            t_len  = '0;
            t_cur  = '0;
            o_kind = KIND_COMMIT;
            if (len_c != '0) begin
              out_load = 1'b0;
              rem_next = len_c;
              st_next  = ST_EMIT;
            end
          end else if (key_byte == KEY_BACKSPACE) begin
            if (t_cur != '0) begin
              ctl   = '{op: CELL_DEL, pos: t_cur - LEN_W'(1), ch: '0};
              t_cur = t_cur - LEN_W'(1);
              t_len = t_len - LEN_W'(1);
            end
          end else if (key_byte >= KEY_PRINT_LO && key_byte <= KEY_PRINT_HI) begin
            if (t_len < lim) begin
              ctl   = '{op: CELL_INS, pos: t_cur, ch: key_byte};
              t_cur = t_cur + LEN_W'(1);
              t_len = t_len + LEN_W'(1);
            end
          end
          len_next = t_len;
          cur_next = t_cur;
        end
      end
      ST_EMIT: begin
        t_len = '0;
        t_cur = '0;
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          o_kind   = KIND_COMMIT;
          o_char   = chars[0];
          o_cv     = 1'b1;
          o_last   = (rem == LEN_W'(1));
          ctl      = '{op: CELL_DEL, pos: '0, ch: '0};
          rem_next = rem - LEN_W'(1);
          if (rem == LEN_W'(1)) st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_IDLE;
      len        <= '0;
      cur        <= '0;
      rem        <= '0;
      prefix     <= 1'b0;
      line_limit <= LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      st     <= st_next;
      len    <= len_next;
      cur    <= cur_next;
      rem    <= rem_next;
      prefix <= prefix_next;
      if (cfg_valid && cfg_ready) line_limit <= cfg_data;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_kind  <= o_kind;
      line_char   <= o_char;
      char_valid  <= o_cv;
      line_length <= t_len;
      cursor_pos  <= t_cur;
      last        <= o_last;
    end
  end

endmodule

FILE: src/leb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks on the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker
  import leb_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] event_kind,
  input logic [CHAR_W-1:0] line_char,
  input logic              char_valid,
  input logic [LEN_W-1:0]  line_length,
  input logic [LEN_W-1:0]  cursor_pos,
  input logic              last
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line_char) && $stable(last)
      && $stable(event_kind) && $stable(line_length) && $stable(cursor_pos))
    else $error("output beat changed while stalled");

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cursor_pos <= line_length && line_length <= 7'd64)
    else $error("cursor beyond line or line too long");

  a_char_only_commit: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> event_kind == KIND_COMMIT && line_length == '0
      && cursor_pos == '0)
    else $error("character beat outside a commit");

  a_commit_blocks_keys: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid && !last |-> !in_ready)
    else $error("key taken in the middle of a commit");

  a_non_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> line_char == '0 && last)
    else $error("status beat with character or not last");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
